// File: design/tpa_pkg.sv
package tpa_pkg;

	typedef struct packed {
		logic signed [15:0] first_azimuth;
		logic signed [15:0] first_polar;
		logic signed [15:0] second_azimuth;
		logic signed [15:0] second_polar;
		logic [2:0]         detector_id;
	} hit_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_ID   = 2'd1,
		ST_ZERO_LEN = 2'd2
	} status_t;

	typedef struct packed {
		logic [14:0] track_angle;
		status_t     status;
	} result_t;

	typedef enum logic [0:0] {
		REG_INNER_RADIUS = 1'b0,
		REG_OUTER_RADIUS = 1'b1
	} reg_index_t;

	localparam logic [15:0] INNER_RADIUS_RESET = 16'd16673;
	localparam logic [15:0] OUTER_RADIUS_RESET = 16'd18209;
	localparam logic [2:0]  DET_ID_A = 3'd1;
	localparam logic [2:0]  DET_ID_B = 3'd3;
	localparam logic [14:0] ANGLE_MAX = 15'd25736;

	localparam logic [33:0] PI_Q30   = 34'd3373259426;
	localparam logic [33:0] GAIN_Q30 = 34'd652032874;

	localparam logic [29:0] ATAN_Q30 [24] = '{
		30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
		30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
		30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
		30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
		30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
	};

	// Difference vector widths; these do not depend on the angle precision.
	localparam int E_W   = 27;
	localparam int DZ_W  = 26;
	localparam int SQ_W  = 52;
	localparam int SUM_W = 54;
	localparam int LEN_W = 27;

	typedef struct packed {
		logic valid;
		logic bad_id;
	} tag_t;

	typedef struct packed {
		logic neg;
		logic zero_len;
		logic bad_id;
	} flags_t;

	typedef struct packed {
		logic [DZ_W-1:0] dz_mag;
		flags_t          flags;
	} side1_t;

	function automatic logic [33:0] scale_q30(logic [33:0] v, int f);
		return v >> (30 - f);
	endfunction

endpackage

// File: design/tpa_sincos.sv
module tpa_sincos #(
	parameter int ANGLE_BITS    = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic signed [15:0]          angle [4],
	input  tpa_pkg::tag_t               tag,
	output logic signed [ANGLE_BITS+2:0] cosine [4],
	output logic signed [ANGLE_BITS+2:0] sine [4],
	output tpa_pkg::tag_t               tag_out
);

	localparam int F  = ANGLE_BITS;
	localparam int N  = CORDIC_STAGES;
	localparam int XW = F + 3;
	localparam int ZW = F + 4;

	localparam logic [33:0] PI_W = tpa_pkg::scale_q30(tpa_pkg::PI_Q30, F);
	localparam logic signed [ZW-1:0] PI_F = $signed({1'b0, PI_W[F+2:0]});
	localparam logic signed [ZW-1:0] HALF_PI = PI_F >>> 1;
	localparam logic [33:0] GAIN_W = tpa_pkg::scale_q30(tpa_pkg::GAIN_Q30, F);
	localparam logic signed [XW-1:0] X0 = $signed({3'b000, GAIN_W[F-1:0]});

	logic signed [ZW-1:0] zin [4];
	logic signed [ZW-1:0] zred [4];
	logic                 flip [4];

	logic signed [XW-1:0] x_s [N+1][4];
	logic signed [XW-1:0] y_s [N+1][4];
	logic signed [ZW-1:0] z_s [N+1][4];
	logic                 f_s [N+1][4];
	tpa_pkg::tag_t        tag_s [N+1];

	// Input angle to Q(F), then fold into the range of plus or minus half pi.
	for (genvar l = 0; l < 4; l++) begin : g_lane
		if (F >= 13) begin : g_up
			assign zin[l] = ZW'(angle[l]) <<< (F - 13);
		end else begin : g_dn
			assign zin[l] = ZW'(angle[l] >>> (13 - F));
		end

		always_comb begin
			if (zin[l] > HALF_PI) begin
				zred[l] = zin[l] - PI_F;
				flip[l] = 1'b1;
			end else if (zin[l] < -HALF_PI) begin
				zred[l] = zin[l] + PI_F;
				flip[l] = 1'b1;
			end else begin
				zred[l] = zin[l];
				flip[l] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				x_s[0][l] <= X0;
				y_s[0][l] <= '0;
				z_s[0][l] <= zred[l];
				f_s[0][l] <= flip[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s[0] <= '0;
		end else if (en) begin
			tag_s[0] <= tag;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam logic [33:0] AT_W = tpa_pkg::scale_q30(34'(tpa_pkg::ATAN_Q30[i]), F);
		localparam logic signed [ZW-1:0] AT = $signed({3'b000, AT_W[F:0]});

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 4; l++) begin
					if (z_s[i][l] >= 0) begin
						x_s[i+1][l] <= x_s[i][l] - (y_s[i][l] >>> i);
						y_s[i+1][l] <= y_s[i][l] + (x_s[i][l] >>> i);
						z_s[i+1][l] <= z_s[i][l] - AT;
					end else begin
						x_s[i+1][l] <= x_s[i][l] + (y_s[i][l] >>> i);
						y_s[i+1][l] <= y_s[i][l] - (x_s[i][l] >>> i);
						z_s[i+1][l] <= z_s[i][l] + AT;
					end
					f_s[i+1][l] <= f_s[i][l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[i+1] <= '0;
			end else if (en) begin
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	// A folded angle gives both results negated.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				cosine[l] <= f_s[N][l] ? -x_s[N][l] : x_s[N][l];
				sine[l]   <= f_s[N][l] ? -y_s[N][l] : y_s[N][l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_out <= '0;
		end else if (en) begin
			tag_out <= tag_s[N];
		end
	end

endmodule

// File: design/tpa_isqrt.sv
module tpa_isqrt #(
	parameter int W      = 54,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid,
	input  logic [W-1:0]      radicand,
	input  logic [SIDE_W-1:0] side,
	output logic              valid_out,
	output logic [W/2-1:0]    root,
	output logic [SIDE_W-1:0] side_out
);

	localparam int K = W / 2;

	logic [W-1:0]      v_s [K];
	logic [W-1:0]      r_s [K];
	logic [SIDE_W-1:0] sd_s [K];
	logic              vld_s [K];

	// One result bit per stage, from the top pair of radicand bits down.
	for (genvar k = 0; k < K; k++) begin : g_stage
		localparam logic [W-1:0] B = W'(1) << (2 * (K - 1 - k));

		logic [W-1:0]      vi;
		logic [W-1:0]      ri;
		logic [W-1:0]      rb;
		logic [SIDE_W-1:0] si;
		logic              vv;

		if (k == 0) begin : g_first
			assign vi = radicand;
			assign ri = '0;
			assign si = side;
			assign vv = valid;
		end else begin : g_next
			assign vi = v_s[k-1];
			assign ri = r_s[k-1];
			assign si = sd_s[k-1];
			assign vv = vld_s[k-1];
		end

		assign rb = ri + B;

		always_ff @(posedge clk) begin
			if (en) begin
				if (vi >= rb) begin
					v_s[k] <= vi - rb;
					r_s[k] <= (ri >> 1) + B;
				end else begin
					v_s[k] <= vi;
					r_s[k] <= ri >> 1;
				end
				sd_s[k] <= si;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vv;
			end
		end
	end

	assign root      = r_s[K-1][K-1:0];
	assign side_out  = sd_s[K-1];
	assign valid_out = vld_s[K-1];

endmodule

// File: design/track_polar_angle.sv
// Throughput: one transaction per cycle while in_stall is low; every stage,
// including the square roots, the divider and both CORDIC units, is fully
// pipelined, and all stages hold together while the output skid entry is full.
// Reset: arst_n clears all valid bits, the output skid stage and loads both
// radius registers with their default values.
module track_polar_angle #(
	parameter int ANGLE_BITS    = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  tpa_pkg::hit_t     in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output tpa_pkg::result_t  out_data,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	localparam int F   = ANGLE_BITS;
	localparam int N   = CORDIC_STAGES;
	localparam int XW  = F + 3;
	localparam int ZW  = F + 4;
	localparam int PW  = XW + 17;
	localparam int DW  = PW + 1;
	localparam int RW  = F + 8;
	localparam int SW2 = 2 * F + 2;
	localparam int EW  = tpa_pkg::E_W;
	localparam int LW  = tpa_pkg::LEN_W;
	localparam int FLW = $bits(tpa_pkg::flags_t);
	localparam int S1W = $bits(tpa_pkg::side1_t);

	localparam logic [33:0] PI_W = tpa_pkg::scale_q30(tpa_pkg::PI_Q30, F);
	localparam logic signed [ZW-1:0] PI_F = $signed({1'b0, PI_W[F+2:0]});
	localparam logic signed [ZW-1:0] HALF_PI = PI_F >>> 1;
	localparam logic [F:0] ONE = (F+1)'(1) << F;
	localparam logic [SW2-1:0] ONE_SQ = SW2'(1) << (2 * F);
	localparam logic signed [RW-1:0] AMAX = $signed(RW'(tpa_pkg::ANGLE_MAX));

	logic [15:0] inner_q;
	logic [15:0] outer_q;
	logic        en;
	logic        skid_q;
	logic        out_valid_q;
	tpa_pkg::result_t out_q;
	tpa_pkg::result_t skid_d_q;

	assign en       = !skid_q;
	assign in_stall = skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= tpa_pkg::INNER_RADIUS_RESET;
			outer_q <= tpa_pkg::OUTER_RADIUS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tpa_pkg::REG_INNER_RADIUS: inner_q <= cfg_data;
				tpa_pkg::REG_OUTER_RADIUS: outer_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sine and cosine of all four angles.
	logic signed [15:0]   ang [4];
	tpa_pkg::tag_t        tag_in;
	tpa_pkg::tag_t        tag_sc;
	logic signed [XW-1:0] cs [4];
	logic signed [XW-1:0] sn [4];

	assign ang[0] = in_data.first_azimuth;
	assign ang[1] = in_data.first_polar;
	assign ang[2] = in_data.second_azimuth;
	assign ang[3] = in_data.second_polar;

	always_comb begin
		tag_in.valid  = in_valid;
		tag_in.bad_id = !(in_data.detector_id == tpa_pkg::DET_ID_A ||
			in_data.detector_id == tpa_pkg::DET_ID_B);
	end

	tpa_sincos #(
		.ANGLE_BITS    (F),
		.CORDIC_STAGES (N)
	) u_sincos (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.angle   (ang),
		.tag     (tag_in),
		.cosine  (cs),
		.sine    (sn),
		.tag_out (tag_sc)
	);

	// Stage 1: horizontal projections cos(az)*sin(pol) and sin(az)*sin(pol).
	logic signed [2*XW-1:0] pr [4];
	logic signed [XW-1:0]   t_s1 [4];
	logic signed [XW-1:0]   cz_s1 [2];
	logic                   bad_s1;
	logic                   v_s1;

	assign pr[0] = cs[0] * sn[1];
	assign pr[1] = sn[0] * sn[1];
	assign pr[2] = cs[2] * sn[3];
	assign pr[3] = sn[2] * sn[3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				t_s1[j] <= XW'(pr[j] >>> F);
			end
			cz_s1[0] <= cs[1];
			cz_s1[1] <= cs[3];
			bad_s1   <= tag_sc.bad_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= tag_sc.valid;
		end
	end

	// Stage 2: scale by the radii. Order: x1, y1, z1, x2, y2, z2.
	logic signed [PW-1:0] p_s2 [6];
	logic signed [16:0]   rin;
	logic signed [16:0]   rout;
	logic                 bad_s2;
	logic                 v_s2;

	assign rin  = $signed({1'b0, inner_q});
	assign rout = $signed({1'b0, outer_q});

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= rin * t_s1[0];
			p_s2[1] <= rin * t_s1[1];
			p_s2[2] <= rin * cz_s1[0];
			p_s2[3] <= rout * t_s1[2];
			p_s2[4] <= rout * t_s1[3];
			p_s2[5] <= rout * cz_s1[1];
			bad_s2  <= bad_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	// Stage 3: difference vector in Q8.
	logic signed [DW-1:0] df [3];
	logic signed [EW-1:0] e_s3 [3];
	logic                 bad_s3;
	logic                 v_s3;

	for (genvar k = 0; k < 3; k++) begin : g_diff
		assign df[k] = DW'(p_s2[k+3]) - DW'(p_s2[k]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				e_s3[k] <= EW'(df[k] >>> (F - 8));
			end
			bad_s3 <= bad_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	// Stage 4: squares. The sum is zero exactly when every component is zero.
	logic signed [2*EW-1:0]      sqf [3];
	logic signed [EW-1:0]        ez_abs;
	logic [tpa_pkg::SQ_W-1:0]    sq_s4 [3];
	logic [tpa_pkg::DZ_W-1:0]    dzm_s4;
	tpa_pkg::flags_t             fl_s4;
	logic                        v_s4;

	for (genvar k = 0; k < 3; k++) begin : g_sq
		assign sqf[k] = e_s3[k] * e_s3[k];
	end

	assign ez_abs = (e_s3[2] < 0) ? -e_s3[2] : e_s3[2];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s4[k] <= sqf[k][tpa_pkg::SQ_W-1:0];
			end
			dzm_s4         <= ez_abs[tpa_pkg::DZ_W-1:0];
			fl_s4.neg      <= e_s3[2] < 0;
			fl_s4.zero_len <= (e_s3[0] == '0) && (e_s3[1] == '0) && (e_s3[2] == '0);
			fl_s4.bad_id   <= bad_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	// Stage 5: sum of squares.
	logic [tpa_pkg::SUM_W-1:0] sum_s5;
	tpa_pkg::side1_t           sd_s5;
	logic                      v_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s5 <= tpa_pkg::SUM_W'(sq_s4[0]) + tpa_pkg::SUM_W'(sq_s4[1]) +
				tpa_pkg::SUM_W'(sq_s4[2]);
			sd_s5.dz_mag <= dzm_s4;
			sd_s5.flags  <= fl_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	// Vector length.
	logic [LW-1:0]   len_r1;
	logic [S1W-1:0]  sd_r1;
	tpa_pkg::side1_t side_r1;
	logic            v_r1;

	tpa_isqrt #(
		.W      (tpa_pkg::SUM_W),
		.SIDE_W (S1W)
	) u_len (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (v_s5),
		.radicand  (sum_s5),
		.side      (sd_s5),
		.valid_out (v_r1),
		.root      (len_r1),
		.side_out  (sd_r1)
	);

	assign side_r1 = tpa_pkg::side1_t'(sd_r1);

	// Divider: |dz| * 2^F / len, one quotient bit per stage, MSB first.
	// |dz| never exceeds len, so the remainder stays below len.
	logic [LW-1:0]   dr_s [F+1];
	logic [LW-1:0]   dl_s [F+1];
	logic [F:0]      dq_s [F+1];
	tpa_pkg::flags_t dfl_s [F+1];
	logic            dv_s [F+1];

	for (genvar k = 0; k <= F; k++) begin : g_div
		logic [LW:0]     ri;
		logic [LW-1:0]   li;
		logic [F:0]      qi;
		tpa_pkg::flags_t fi;
		logic            vi;
		logic            ge;

		if (k == 0) begin : g_first
			assign ri = (LW+1)'(side_r1.dz_mag);
			assign li = len_r1;
			assign qi = '0;
			assign fi = side_r1.flags;
			assign vi = v_r1;
		end else begin : g_next
			assign ri = {dr_s[k-1], 1'b0};
			assign li = dl_s[k-1];
			assign qi = dq_s[k-1];
			assign fi = dfl_s[k-1];
			assign vi = dv_s[k-1];
		end

		assign ge = ri >= {1'b0, li};

		always_ff @(posedge clk) begin
			if (en) begin
				dr_s[k]  <= ge ? LW'(ri - {1'b0, li}) : LW'(ri);
				dl_s[k]  <= li;
				dq_s[k]  <= {qi[F-1:0], ge};
				dfl_s[k] <= fi;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k] <= 1'b0;
			end else if (en) begin
				dv_s[k] <= vi;
			end
		end
	end

	// Stage 7: clamp the cosine magnitude and form 1 - c^2.
	logic [F:0]       mag_c;
	logic [SW2-1:0]   msq_c;
	logic [F:0]       mag_s7;
	logic [SW2-1:0]   rad_s7;
	tpa_pkg::flags_t  fl_s7;
	logic             v_s7;

	assign mag_c = (dq_s[F] > ONE) ? ONE : dq_s[F];
	assign msq_c = SW2'(mag_c) * SW2'(mag_c);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s7 <= mag_c;
			rad_s7 <= ONE_SQ - msq_c;
			fl_s7  <= dfl_s[F];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= dv_s[F];
		end
	end

	// Sine of the track angle.
	logic [F:0]       sin_r2;
	logic [F+FLW:0]   sd_r2;
	logic             v_r2;

	tpa_isqrt #(
		.W      (SW2),
		.SIDE_W (F + 1 + FLW)
	) u_sin (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (v_s7),
		.radicand  (rad_s7),
		.side      ({mag_s7, fl_s7}),
		.valid_out (v_r2),
		.root      (sin_r2),
		.side_out  (sd_r2)
	);

	// Stage 8: vectoring start. A negative cosine starts a quarter turn ahead.
	logic [F:0]           mag_r2;
	tpa_pkg::flags_t      fl_r2;
	logic signed [XW-1:0] vx_s8;
	logic signed [XW-1:0] vy_s8;
	logic signed [ZW-1:0] vz_s8;
	tpa_pkg::flags_t      fl_s8;
	logic                 v_s8;

	assign mag_r2 = sd_r2[F+FLW:FLW];
	assign fl_r2  = tpa_pkg::flags_t'(sd_r2[FLW-1:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			if (fl_r2.neg) begin
				vx_s8 <= XW'(sin_r2);
				vy_s8 <= XW'(mag_r2);
				vz_s8 <= HALF_PI;
			end else begin
				vx_s8 <= XW'(mag_r2);
				vy_s8 <= XW'(sin_r2);
				vz_s8 <= '0;
			end
			fl_s8 <= fl_r2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_r2;
		end
	end

	// Vectoring CORDIC: drive y to zero, accumulate the angle in z.
	logic signed [XW-1:0] vx_s [N];
	logic signed [XW-1:0] vy_s [N];
	logic signed [ZW-1:0] vz_s [N];
	tpa_pkg::flags_t      vf_s [N];
	logic                 vv_s [N];

	for (genvar i = 0; i < N; i++) begin : g_vec
		localparam logic [33:0] AT_W = tpa_pkg::scale_q30(34'(tpa_pkg::ATAN_Q30[i]), F);
		localparam logic signed [ZW-1:0] AT = $signed({3'b000, AT_W[F:0]});

		logic signed [XW-1:0] xi;
		logic signed [XW-1:0] yi;
		logic signed [ZW-1:0] zi;
		tpa_pkg::flags_t      fi;
		logic                 vi;

		if (i == 0) begin : g_first
			assign xi = vx_s8;
			assign yi = vy_s8;
			assign zi = vz_s8;
			assign fi = fl_s8;
			assign vi = v_s8;
		end else begin : g_next
			assign xi = vx_s[i-1];
			assign yi = vy_s[i-1];
			assign zi = vz_s[i-1];
			assign fi = vf_s[i-1];
			assign vi = vv_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (yi >= 0) begin
					vx_s[i] <= xi + (yi >>> i);
					vy_s[i] <= yi - (xi >>> i);
					vz_s[i] <= zi + AT;
				end else begin
					vx_s[i] <= xi - (yi >>> i);
					vy_s[i] <= yi + (xi >>> i);
					vz_s[i] <= zi - AT;
				end
				vf_s[i] <= fi;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vv_s[i] <= 1'b0;
			end else if (en) begin
				vv_s[i] <= vi;
			end
		end
	end

	// Stage 9: to unsigned Q2.13 with rounding half up, clamp, status.
	logic signed [RW-1:0] zr;
	tpa_pkg::result_t     res_c;
	tpa_pkg::result_t     res_s9;
	logic                 v_s9;

	if (F > 13) begin : g_rnd_dn
		localparam logic signed [RW-1:0] RND = RW'(1) << (F - 14);
		assign zr = (RW'(vz_s[N-1]) + RND) >>> (F - 13);
	end else if (F < 13) begin : g_rnd_up
		assign zr = RW'(vz_s[N-1]) <<< (13 - F);
	end else begin : g_rnd_eq
		assign zr = RW'(vz_s[N-1]);
	end

	always_comb begin
		res_c.track_angle = '0;
		res_c.status      = tpa_pkg::ST_OK;
		if (vf_s[N-1].bad_id) begin
			res_c.status = tpa_pkg::ST_BAD_ID;
		end else if (vf_s[N-1].zero_len) begin
			res_c.status = tpa_pkg::ST_ZERO_LEN;
		end else if (zr < 0) begin
			res_c.track_angle = '0;
		end else if (zr > AMAX) begin
			res_c.track_angle = tpa_pkg::ANGLE_MAX;
		end else begin
			res_c.track_angle = zr[14:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s9 <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= vv_s[N-1];
		end
	end

	// Output register with a one-entry skid stage. The pipeline only moves
	// while the skid entry is empty, so nothing is dropped when out_stall rises.
	logic take;
	logic out_free;

	assign take     = en && v_s9;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_q      <= 1'b0;
		end else if (out_free) begin
			if (skid_q) begin
				out_valid_q <= 1'b1;
				skid_q      <= 1'b0;
			end else begin
				out_valid_q <= take;
			end
		end else if (take) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_q ? skid_d_q : res_s9;
		end else if (take) begin
			skid_d_q <= res_s9;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q |-> out_valid_q)
		else $error("skid entry held without a pending output transaction");

	a_skid_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid entry filled while the output was free");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status != tpa_pkg::ST_OK) |-> out_q.track_angle == '0)
		else $error("nonzero angle reported with an error status");

	a_angle_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.track_angle <= tpa_pkg::ANGLE_MAX)
		else $error("track angle above pi");

endmodule

// File: tb/sv/track_polar_angle_tb.sv
module track_polar_angle_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ANGLE_F   = 16;
	localparam int STAGES    = 16;
	localparam int LATENCY   = 2 * STAGES + 2 * ANGLE_F + 40;
	localparam int IDLE_LIMIT = 5000;

	typedef struct {
		tpa_pkg::hit_t    h;
		bit               typed;
		tpa_pkg::result_t r;
	} row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	tpa_pkg::hit_t    in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	tpa_pkg::result_t out_data;
	logic             cfg_we = 1'b0;
	logic [0:0]       cfg_index = tpa_pkg::REG_INNER_RADIUS;
	logic [15:0]      cfg_data = '0;

	logic [15:0]      inner_r = tpa_pkg::INNER_RADIUS_RESET;
	logic [15:0]      outer_r = tpa_pkg::OUTER_RADIUS_RESET;
	tpa_pkg::result_t angle_q[$];
	int               errors = 0;
	int               sender_gap_max = 18;
	bit               receiver_busy_free = 1'b0;
	bit               hold_req = 1'b0;

	track_polar_angle u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic longint atan_step(int i);
		return longint'(tpa_pkg::ATAN_Q30[i]) >>> (30 - ANGLE_F);
	endfunction

	function automatic longint half_pi();
		return (longint'(tpa_pkg::PI_Q30) >>> (30 - ANGLE_F)) >>> 1;
	endfunction

	function automatic longint root_floor(longint v);
		longint r, b;
		r = 0;
		b = longint'(1) << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Rotation CORDIC with one half-turn fold for angles beyond +-pi/2.
	task automatic sin_cos(input logic signed [15:0] a, output longint c, output longint s);
		longint z, x, y, xs, ys, pi_v;
		bit flip;
		pi_v = longint'(tpa_pkg::PI_Q30) >>> (30 - ANGLE_F);
		z = longint'(a) * (longint'(1) << (ANGLE_F - 13));
		flip = 1'b0;
		if (z > half_pi()) begin
			z = z - pi_v;
			flip = 1'b1;
		end else if (z < -half_pi()) begin
			z = z + pi_v;
			flip = 1'b1;
		end
		x = longint'(tpa_pkg::GAIN_Q30) >>> (30 - ANGLE_F);
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys; y = y + xs; z = z - atan_step(i);
			end else begin
				x = x + ys; y = y - xs; z = z + atan_step(i);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic hit_point(input logic signed [15:0] az, input logic signed [15:0] pol,
			input logic [15:0] r, output longint p [3]);
		longint ca, sa, cp, sp;
		sin_cos(az, ca, sa);
		sin_cos(pol, cp, sp);
		p[0] = longint'(r) * ((ca * sp) >>> ANGLE_F);
		p[1] = longint'(r) * ((sa * sp) >>> ANGLE_F);
		p[2] = longint'(r) * cp;
	endtask

	task automatic polar_angle_of(input tpa_pkg::hit_t h, output tpa_pkg::result_t res);
		longint p1 [3], p2 [3], e [3];
		longint sum, len, mag, c, x, y, z, xs, ys, one;
		res.track_angle = '0;
		res.status = tpa_pkg::ST_OK;
		one = longint'(1) << ANGLE_F;
		if (h.detector_id != tpa_pkg::DET_ID_A && h.detector_id != tpa_pkg::DET_ID_B) begin
			res.status = tpa_pkg::ST_BAD_ID;
			return;
		end
		hit_point(h.first_azimuth, h.first_polar, inner_r, p1);
		hit_point(h.second_azimuth, h.second_polar, outer_r, p2);
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			e[i] = (p2[i] - p1[i]) >>> (ANGLE_F - 8);
			sum = sum + e[i] * e[i];
		end
		if (sum == 0) begin
			res.status = tpa_pkg::ST_ZERO_LEN;
			return;
		end
		len = root_floor(sum);
		mag = ((e[2] < 0) ? -e[2] : e[2]) * one / len;
		if (mag > one)
			mag = one;
		c = (e[2] < 0) ? -mag : mag;
		y = root_floor(one * one - mag * mag);
		if (c < 0) begin
			x = y; y = -c; z = half_pi();
		end else begin
			x = c; z = 0;
		end
		// Vectoring CORDIC drives y to zero; z collects the angle.
		for (int i = 0; i < STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + atan_step(i);
			end else begin
				x = x - ys; y = y + xs; z = z - atan_step(i);
			end
		end
		z = (z + (longint'(1) << (ANGLE_F - 14))) >>> (ANGLE_F - 13);
		if (z < 0)
			z = 0;
		if (z > longint'(tpa_pkg::ANGLE_MAX))
			z = longint'(tpa_pkg::ANGLE_MAX);
		res.track_angle = z[14:0];
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Result checker; handshake signals are sampled at the falling edge.
	initial begin
		logic             v, s;
		tpa_pkg::result_t d, want;
		forever begin
			@(negedge clk);
			v = out_valid;
			s = out_stall;
			d = out_data;
			@(posedge clk);
			if (arst_n && v && !s) begin
				if (angle_q.size() == 0) begin
					report_mismatch("unexpected result transaction", 1, 0);
				end else begin
					want = angle_q.pop_front();
					if (d.track_angle !== want.track_angle)
						report_mismatch("track_angle", int'(d.track_angle),
							int'(want.track_angle));
					if (d.status !== want.status)
						report_mismatch("status", int'(d.status), int'(want.status));
				end
			end
		end
	end

	// Receiver back-pressure.
	initial begin
		int  k;
		logic seen;
		@(posedge arst_n);
		forever begin
			k = receiver_busy_free ? 0 : $urandom_range(0, 18);
			if (hold_req) begin
				k = 400;
				hold_req = 1'b0;
			end
			if (k > 0) begin
				out_stall <= 1'b1;
				repeat (k) @(posedge clk);
			end
			out_stall <= 1'b0;
			do begin
				@(negedge clk);
				seen = out_valid;
				@(posedge clk);
			end while (!seen);
		end
	end

	initial begin
		int quiet;
		logic moved;
		quiet = 0;
		forever begin
			@(negedge clk);
			moved = (in_valid && !in_stall) || (out_valid && !out_stall);
			@(posedge clk);
			quiet = moved ? 0 : quiet + 1;
			if (quiet >= IDLE_LIMIT) begin
				$display("** track_polar_angle: FAILED **");
				$finish;
			end
		end
	end

	task automatic send_hit(input tpa_pkg::hit_t h, input bit typed,
			input tpa_pkg::result_t r);
		int               gap;
		logic             st;
		tpa_pkg::result_t want;
		gap = $urandom_range(0, sender_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= h;
		do begin
			@(negedge clk);
			st = in_stall;
			@(posedge clk);
		end while (st);
		if (typed)
			want = r;
		else
			polar_angle_of(h, want);
		angle_q.push_back(want);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (angle_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic set_radii(input logic [15:0] a, input logic [15:0] b);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= tpa_pkg::REG_INNER_RADIUS;
		cfg_data  <= a;
		@(posedge clk);
		cfg_index <= tpa_pkg::REG_OUTER_RADIUS;
		cfg_data  <= b;
		@(posedge clk);
		cfg_we <= 1'b0;
		inner_r = a;
		outer_r = b;
	endtask

	function automatic logic [15:0] pick_angle();
		logic [15:0] corner [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
		case ($urandom_range(0, 9))
			0: return corner[$urandom_range(0, 3)];
			1, 2, 3: return 16'($urandom);
			default: return 16'($urandom_range(0, 51472) - 25736);
		endcase
	endfunction

	function automatic tpa_pkg::hit_t random_hit();
		tpa_pkg::hit_t h;
		h.first_azimuth  = pick_angle();
		h.first_polar    = pick_angle();
		h.second_azimuth = pick_angle();
		h.second_polar   = pick_angle();
		if ($urandom_range(0, 9) == 0)
			h.detector_id = 3'($urandom_range(0, 7));
		else
			h.detector_id = $urandom_range(0, 1) ? tpa_pkg::DET_ID_B : tpa_pkg::DET_ID_A;
		return h;
	endfunction

	function automatic row_t mk_row(logic [15:0] a1, logic [15:0] p1, logic [15:0] a2,
			logic [15:0] p2, logic [2:0] id, bit typed, tpa_pkg::status_t st);
		row_t w;
		w.h = '{a1, p1, a2, p2, id};
		w.typed = typed;
		w.r.track_angle = '0;
		w.r.status = st;
		return w;
	endfunction

	initial begin
		row_t             rows[$];
		row_t             w;
		tpa_pkg::result_t none;
		none = '0;

		// A bad detector id wins regardless of the angles.
		rows.push_back(mk_row(16'h1234, 16'h0800, 16'h8000, 16'h7FFF, 3'd0, 1,
			tpa_pkg::ST_BAD_ID));
		rows.push_back(mk_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 3'd2, 1,
			tpa_pkg::ST_BAD_ID));
		rows.push_back(mk_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 3'd4, 1,
			tpa_pkg::ST_BAD_ID));
		rows.push_back(mk_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'd5, 1,
			tpa_pkg::ST_BAD_ID));
		rows.push_back(mk_row(16'hFFFF, 16'h3000, 16'h0001, 16'h1000, 3'd6, 1,
			tpa_pkg::ST_BAD_ID));
		rows.push_back(mk_row(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 3'd7, 1,
			tpa_pkg::ST_BAD_ID));
		rows.push_back(mk_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, tpa_pkg::DET_ID_A, 0,
			tpa_pkg::ST_OK));
		rows.push_back(mk_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, tpa_pkg::DET_ID_B, 0,
			tpa_pkg::ST_OK));
		rows.push_back(mk_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, tpa_pkg::DET_ID_A, 0,
			tpa_pkg::ST_OK));
		rows.push_back(mk_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, tpa_pkg::DET_ID_B, 0,
			tpa_pkg::ST_OK));
		rows.push_back(mk_row(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, tpa_pkg::DET_ID_A, 0,
			tpa_pkg::ST_OK));
		rows.push_back(mk_row(16'h0000, 16'h3244, 16'h0000, 16'h3244, tpa_pkg::DET_ID_A, 0,
			tpa_pkg::ST_OK));
		rows.push_back(mk_row(16'h1922, 16'h1922, 16'h1922, 16'h1922, tpa_pkg::DET_ID_B, 0,
			tpa_pkg::ST_OK));
		rows.push_back(mk_row(16'h6488, 16'h6488, 16'h9B78, 16'h9B78, tpa_pkg::DET_ID_A, 0,
			tpa_pkg::ST_OK));
		rows.push_back(mk_row(16'h6489, 16'h9B77, 16'h0000, 16'h0000, tpa_pkg::DET_ID_B, 0,
			tpa_pkg::ST_OK));
		rows.push_back(mk_row(16'h0000, 16'h0000, 16'h0000, 16'h6488, tpa_pkg::DET_ID_A, 0,
			tpa_pkg::ST_OK));
		rows.push_back(mk_row(16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF, tpa_pkg::DET_ID_B, 0,
			tpa_pkg::ST_OK));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_hit(rows[i].h, rows[i].typed, rows[i].r);

		// Both radii zero: every good hit pair collapses to a point.
		set_radii(16'd0, 16'd0);
		for (int i = 0; i < 4; i++) begin
			w = mk_row(pick_angle(), pick_angle(), pick_angle(), pick_angle(),
				(i % 2) ? tpa_pkg::DET_ID_B : tpa_pkg::DET_ID_A, 1, tpa_pkg::ST_ZERO_LEN);
			send_hit(w.h, 1, w.r);
		end
		// Equal radii and identical hits also give a zero-length track.
		set_radii(16'hFFFF, 16'hFFFF);
		w = mk_row(16'h1000, 16'h2000, 16'h1000, 16'h2000, tpa_pkg::DET_ID_A, 1,
			tpa_pkg::ST_ZERO_LEN);
		send_hit(w.h, 1, w.r);
		send_hit(rows[8].h, 0, none);

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_radii(tpa_pkg::INNER_RADIUS_RESET, tpa_pkg::OUTER_RADIUS_RESET);
				1: set_radii(16'hFFFF, 16'd0);
				2: set_radii(16'd0, 16'hFFFF);
				3: set_radii(16'd1, 16'd2);
				default: set_radii(16'($urandom), 16'($urandom));
			endcase
			sender_gap_max = 18;
			receiver_busy_free = 1'b0;
			if (phase == 1) begin
				// Long receiver hold while the sender streams, so the pipe backs up.
				sender_gap_max = 0;
				hold_req = 1'b1;
			end
			if (phase == 3) begin
				sender_gap_max = 0;
				receiver_busy_free = 1'b1;
			end
			for (int n = 0; n < 215; n++) begin
				if (phase == 4 && n == 100)
					drain();
				send_hit(random_hit(), 0, none);
			end
		end

		drain();
		if (errors == 0)
			$display("** track_polar_angle: PASSED **");
		else
			$display("** track_polar_angle: FAILED **");
		$finish;
	end
endmodule
